/* sv/polyhedral_point_location_core_defines.svh */
// Assertion macros for the file that carries concurrent checks.
// Both macros expect a signal named clk in the enclosing scope; PPL_ASSERT also expects arst_n.
`ifndef POLYHEDRAL_POINT_LOCATION_CORE_DEFINES_SVH
`define POLYHEDRAL_POINT_LOCATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define PPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that also holds while reset is asserted.
`define PPL_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPL_ASSERT(label, prop, msg)
`define PPL_ASSERT_ANY(label, prop, msg)
`endif

`endif

/* sv/ppl_pkg.sv */
package ppl_pkg;

	// Width of every value field on the input stream and fractional bits of Q16.16.
	localparam int VALUE_FIELD_W = 32;
	localparam int FRAC_BITS     = 16;
	localparam int POINT_FIELDS  = 4;

	// Input tdata layout, lowest bit first.
	localparam int REGION_LSB  = 0;
	localparam int REGION_W    = 4;
	localparam int ROW_LSB     = 4;
	localparam int ROW_FIELD_W = 4;
	localparam int COL_LSB     = 8;
	localparam int COL_W       = 2;
	localparam int COEF_LSB    = 10;
	localparam int BOUND_LSB   = 42;
	localparam int COUNT_LSB   = 74;
	localparam int COUNT_W     = 5;
	localparam int POINT0_LSB  = 79;
	localparam int IN_TDATA_W  = 208;
	localparam int IN_TUSER_W  = 2;

	// Output stream layout.
	localparam int HIT_W       = 4;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 1;

	// Configuration registers.
	localparam int DIMS_W      = 3;
	localparam int REGIONS_W   = 5;
	localparam int CFG_DATA_W  = 5;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIMS    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REGIONS = 1'b1;

	// Region scan counter; the region register never exceeds 31.
	localparam int SCAN_W = REGIONS_W;

	typedef enum logic [1:0] {
		OP_WR_COEF,
		OP_WR_BOUND,
		OP_WR_COUNT,
		OP_LOCATE
	} op_t;

	typedef struct packed {
		logic wr_coef;
		logic wr_bound;
		logic wr_count;
		logic load_point;
		logic rd_count;
		logic clear_fail;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic region_active;
		logic busy;
		logic fail;
	} stat_t;

endpackage

/* sv/polyhedral_point_location_core.sv */
// Scan: a write beat updates the tables as it is accepted; a locate beat checks the flag of each
// region in turn and, for an active one, reads the row count, issues its rows and drains the pipeline.
// Throughput: one beat at a time; the region scan issues one constraint row per cycle
// through a MAX_DIMS-lane multiply pipeline fed by one read port per coefficient column.
// Reset: arst_n clears the region flags, registers and handshake state at once; the
// coefficient and bound tables hold no reset value and are valid only where written.
`include "polyhedral_point_location_core_defines.svh"

// Sequential-search point location over a table of polyhedral regions.
//
// Each region is a set of half-space rows H.z <= K in signed Q16.16. Write beats load
// one coefficient of H, one bound of K, or the row count of a region; a legal row count
// also marks the region active. A locate beat carries a point, and the block returns
// the lowest active region below the region register whose every row holds, or a miss.
//
// Every row is checked exactly: each Q16.16 product is a full Q32.32 value, the lanes
// are summed in a wide signed accumulator and compared with K moved to Q32.32.
//
// The controller walks the regions and rows; the datapath owns the tables, the region
// flags and the row pipeline (table read, multiply, pair sum, compare). A region takes
// a flag check, a row count read, one issue per row, and a drain of the pipeline.
// The result sits in an output register, so a new beat is taken while it waits.
module polyhedral_point_location_core #(
	parameter int MAX_REGIONS     = 16,
	parameter int MAX_CONSTRAINTS = 16,
	parameter int MAX_DIMS        = 4,
	parameter int VALUE_WIDTH     = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input beats.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [3:0] region_index, [7:4] constraint_index, [9:8] column_index,
	// [41:10] coefficient, [73:42] bound, [78:74] constraint_count,
	// [110:79] point_0, [142:111] point_1, [174:143] point_2, [206:175] point_3,
	// [207] zero fill
	input  logic [ppl_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [ppl_pkg::IN_TUSER_W-1:0]  s_tuser,
	// Result beats.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [3:0] region_hit, [7:4] zero fill
	output logic [ppl_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] found
	output logic [ppl_pkg::OUT_TUSER_W-1:0] m_tuser,
	// Configuration writes: index 0 dims_in_use, index 1 regions_in_use.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ppl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ppl_pkg::*;

	localparam int ROW_W = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
	localparam int CNT_W = $clog2(MAX_CONSTRAINTS + 1);

	cmd_t               cmd;
	stat_t              stat;
	logic [DIMS_W-1:0]  dims;
	logic [SCAN_W-1:0]  scan_region;
	logic [ROW_W-1:0]   scan_row;
	logic [CNT_W-1:0]   row_count;

	// The controller decodes beats, holds the configuration and runs the scan.
	ppl_ctrl #(
		.MAX_REGIONS     (MAX_REGIONS),
		.MAX_CONSTRAINTS (MAX_CONSTRAINTS),
		.MAX_DIMS        (MAX_DIMS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.dims        (dims),
		.scan_region (scan_region),
		.scan_row    (scan_row),
		.row_count   (row_count)
	);

	// The datapath holds the tables and evaluates one constraint row per cycle.
	ppl_datapath #(
		.MAX_REGIONS     (MAX_REGIONS),
		.MAX_CONSTRAINTS (MAX_CONSTRAINTS),
		.MAX_DIMS        (MAX_DIMS),
		.VALUE_WIDTH     (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.s_tdata     (s_tdata),
		.dims        (dims),
		.scan_region (scan_region),
		.scan_row    (scan_row),
		.row_count   (row_count),
		.stat        (stat)
	);

	// No new beat may enter while rows of the current region are still in flight.
	`PPL_ASSERT(a_busy_blocks_input, stat.busy |-> !s_tready, "beat taken while rows in flight")
	// Table writes happen only on an accepted input beat.
	`PPL_ASSERT(a_write_on_beat, (cmd.wr_coef || cmd.wr_bound || cmd.wr_count) |-> (s_tvalid && s_tready), "table write without an input beat")
	// A miss reports region zero.
	`PPL_ASSERT(a_miss_zero_hit, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "miss with nonzero region")
	// No result is offered right after reset.
	`PPL_ASSERT_ANY(a_reset_drops_valid, !arst_n |=> !m_tvalid, "result valid after reset")

endmodule

/* sv/ppl_ram.sv */
module ppl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/ppl_datapath.sv */
module ppl_datapath #(
	parameter int MAX_REGIONS     = 16,
	parameter int MAX_CONSTRAINTS = 16,
	parameter int MAX_DIMS        = 4,
	parameter int VALUE_WIDTH     = 32,
	localparam int ROW_W = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1,
	localparam int CNT_W = $clog2(MAX_CONSTRAINTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppl_pkg::cmd_t                 cmd,
	input  logic [ppl_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [ppl_pkg::DIMS_W-1:0]    dims,
	input  logic [ppl_pkg::SCAN_W-1:0]    scan_region,
	input  logic [ROW_W-1:0]              scan_row,
	output logic [CNT_W-1:0]              row_count,
	output ppl_pkg::stat_t                stat
);
	import ppl_pkg::*;

	localparam int VW         = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
	localparam int PROD_W     = 2 * VW;
	localparam int ACC_W      = PROD_W + $clog2(MAX_DIMS + 1) + 1;
	localparam int NPAIR      = (MAX_DIMS + 1) / 2;
	localparam int RIDX_W     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int ROWS_TOTAL = MAX_REGIONS * MAX_CONSTRAINTS;
	localparam int ADDR_W     = (ROWS_TOTAL > 1) ? $clog2(ROWS_TOTAL) : 1;

	logic [REGION_W-1:0]    region_f;
	logic [ROW_FIELD_W-1:0] row_f;
	logic [COL_W-1:0]       col_f;
	logic [VW-1:0]          coef_in;
	logic [VW-1:0]          bound_in;
	logic [COUNT_W-1:0]     count_f;
	logic [RIDX_W-1:0]      wr_region;
	logic [RIDX_W-1:0]      rd_region;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ADDR_W-1:0]      rd_addr;

	assign region_f  = s_tdata[REGION_LSB +: REGION_W];
	assign row_f     = s_tdata[ROW_LSB +: ROW_FIELD_W];
	assign col_f     = s_tdata[COL_LSB +: COL_W];
	assign coef_in   = s_tdata[COEF_LSB +: VW];
	assign bound_in  = s_tdata[BOUND_LSB +: VW];
	assign count_f   = s_tdata[COUNT_LSB +: COUNT_W];
	assign wr_region = RIDX_W'(region_f);
	assign rd_region = RIDX_W'(scan_region);
	assign wr_addr   = ADDR_W'(32'(region_f) * MAX_CONSTRAINTS + 32'(row_f));
	assign rd_addr   = ADDR_W'(32'(scan_region) * MAX_CONSTRAINTS + 32'(scan_row));

	// Region flags: a region counts as active once a legal row count was written.
	logic [MAX_REGIONS-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.wr_count) begin
			active_q[wr_region] <= 1'b1;
		end
	end

	ppl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_REGIONS)) u_count_ram (
		.clk   (clk),
		.we    (cmd.wr_count),
		.waddr (wr_region),
		.wdata (CNT_W'(count_f)),
		.re    (cmd.rd_count),
		.raddr (rd_region),
		.rdata (row_count)
	);

	logic [VW-1:0] bound_rd;

	ppl_ram #(.WIDTH(VW), .DEPTH(ROWS_TOTAL)) u_bound_ram (
		.clk   (clk),
		.we    (cmd.wr_bound),
		.waddr (wr_addr),
		.wdata (bound_in),
		.re    (cmd.issue),
		.raddr (rd_addr),
		.rdata (bound_rd)
	);

	logic signed [VW-1:0]     point_q [MAX_DIMS];
	logic signed [PROD_W-1:0] prod_s2 [MAX_DIMS];
	logic signed [ACC_W-1:0]  pair_s3 [NPAIR];
	logic [VW-1:0]            bound_s2;
	logic [VW-1:0]            bound_s3;

	// One lane per coordinate: its column of H, the point coordinate and a multiplier.
	for (genvar c = 0; c < MAX_DIMS; c++) begin : g_lane
		logic [VW-1:0] pt_in;
		logic [VW-1:0] coef_rd;
		logic          lane_on_q;

		if (c < POINT_FIELDS) begin : g_field
			assign pt_in = s_tdata[POINT0_LSB + c * VALUE_FIELD_W +: VW];
		end else begin : g_zero
			assign pt_in = '0;
		end

		// Columns beyond the dimension register get a zero coordinate and a zero
		// product, whatever their table entries hold.
		always_ff @(posedge clk) begin
			if (cmd.load_point) begin
				point_q[c] <= ((c == 0) || (32'(dims) > c)) ? pt_in : '0;
				lane_on_q  <= (c == 0) || (32'(dims) > c);
			end
		end

		ppl_ram #(.WIDTH(VW), .DEPTH(ROWS_TOTAL)) u_coef_ram (
			.clk   (clk),
			.we    (cmd.wr_coef && (32'(col_f) == c)),
			.waddr (wr_addr),
			.wdata (coef_in),
			.re    (cmd.issue),
			.raddr (rd_addr),
			.rdata (coef_rd)
		);

		always_ff @(posedge clk) begin
			if (lane_on_q) begin
				prod_s2[c] <= $signed(coef_rd) * point_q[c];
			end else begin
				prod_s2[c] <= '0;
			end
		end
	end

	for (genvar p = 0; p < NPAIR; p++) begin : g_pair
		if (2 * p + 1 < MAX_DIMS) begin : g_two
			always_ff @(posedge clk) begin
				pair_s3[p] <= ACC_W'(prod_s2[2 * p]) + ACC_W'(prod_s2[2 * p + 1]);
			end
		end else begin : g_one
			always_ff @(posedge clk) begin
				pair_s3[p] <= ACC_W'(prod_s2[2 * p]);
			end
		end
	end

	always_ff @(posedge clk) begin
		bound_s2 <= bound_rd;
		bound_s3 <= bound_s2;
	end

	logic signed [ACC_W-1:0] row_sum;
	logic signed [ACC_W-1:0] bound_scaled;
	logic                    row_fail;

	always_comb begin
		row_sum = '0;
		for (int p = 0; p < NPAIR; p++) begin
			row_sum = row_sum + pair_s3[p];
		end
	end

	// K is Q16.16; moved to Q32.32 it lines up with the products.
	assign bound_scaled = ACC_W'($signed({bound_s3, FRAC_BITS'(0)}));
	assign row_fail     = row_sum > bound_scaled;

	logic v_s1, v_s2, v_s3;
	logic fail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			fail_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.clear_fail) begin
				fail_q <= 1'b0;
			end else if (v_s3 && row_fail) begin
				fail_q <= 1'b1;
			end
		end
	end

	assign stat.region_active = active_q[rd_region];
	assign stat.busy          = v_s1 | v_s2 | v_s3;
	assign stat.fail          = fail_q;

endmodule

/* sv/ppl_ctrl.sv */
module ppl_ctrl #(
	parameter int MAX_REGIONS     = 16,
	parameter int MAX_CONSTRAINTS = 16,
	parameter int MAX_DIMS        = 4,
	localparam int ROW_W = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1,
	localparam int CNT_W = $clog2(MAX_CONSTRAINTS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ppl_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [ppl_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ppl_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [ppl_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ppl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ppl_pkg::cmd_t                   cmd,
	input  ppl_pkg::stat_t                  stat,
	output logic [ppl_pkg::DIMS_W-1:0]      dims,
	output logic [ppl_pkg::SCAN_W-1:0]      scan_region,
	output logic [ROW_W-1:0]                scan_row,
	input  logic [CNT_W-1:0]                row_count
);
	import ppl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REGION,
		ST_COUNT,
		ST_ROWS,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [DIMS_W-1:0]      dims_q;
	logic [REGIONS_W-1:0]   regions_q;
	logic [SCAN_W-1:0]      scan_q;
	logic [ROW_W-1:0]       row_q;
	logic [CNT_W-1:0]       rows_q;
	logic                   found_q;
	logic [HIT_W-1:0]       hit_q;
	logic                   m_valid_q;
	logic                   m_found_q;
	logic [HIT_W-1:0]       m_hit_q;

	logic [REGIONS_W-1:0]   nreg;
	op_t                    op;
	logic                   accept;
	logic [REGION_W-1:0]    region_f;
	logic [ROW_FIELD_W-1:0] row_f;
	logic [COL_W-1:0]       col_f;
	logic [COUNT_W-1:0]     count_f;
	logic                   region_ok;
	logic                   row_ok;
	logic                   col_ok;
	logic                   count_ok;
	logic                   last_row;
	logic                   scan_end;
	logic                   out_load;

	assign nreg = (32'(regions_q) > MAX_REGIONS) ? REGIONS_W'(MAX_REGIONS) : regions_q;

	assign op        = op_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign region_f  = s_tdata[REGION_LSB +: REGION_W];
	assign row_f     = s_tdata[ROW_LSB +: ROW_FIELD_W];
	assign col_f     = s_tdata[COL_LSB +: COL_W];
	assign count_f   = s_tdata[COUNT_LSB +: COUNT_W];
	assign region_ok = REGIONS_W'(region_f) < nreg;
	assign row_ok    = 32'(row_f) < MAX_CONSTRAINTS;
	assign col_ok    = 32'(col_f) < MAX_DIMS;
	assign count_ok  = (count_f != '0) && (32'(count_f) <= MAX_CONSTRAINTS);
	assign last_row  = (32'(row_q) + 32'd1) == 32'(rows_q);
	assign scan_end  = scan_q >= nreg;
	assign out_load  = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_comb begin
		cmd            = '0;
		cmd.wr_coef    = accept && (op == OP_WR_COEF) && region_ok && row_ok && col_ok;
		cmd.wr_bound   = accept && (op == OP_WR_BOUND) && region_ok && row_ok;
		cmd.wr_count   = accept && (op == OP_WR_COUNT) && region_ok && count_ok;
		cmd.load_point = accept && (op == OP_LOCATE);
		cmd.rd_count   = (state_q == ST_REGION) && !scan_end && stat.region_active;
		cmd.clear_fail = state_q == ST_COUNT;
		cmd.issue      = state_q == ST_ROWS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dims_q    <= DIMS_W'(1);
			regions_q <= '0;
			scan_q    <= '0;
			row_q     <= '0;
			rows_q    <= '0;
			found_q   <= 1'b0;
			hit_q     <= '0;
			m_valid_q <= 1'b0;
			m_found_q <= 1'b0;
			m_hit_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DIMS: begin
						dims_q <= cfg_data[DIMS_W-1:0];
					end
					REG_REGIONS: begin
						regions_q <= cfg_data[REGIONS_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load_point) begin
						scan_q  <= '0;
						state_q <= ST_REGION;
					end
				end
				ST_REGION: begin
					if (scan_end) begin
						found_q <= 1'b0;
						hit_q   <= '0;
						state_q <= ST_DONE;
					end else if (!stat.region_active) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					row_q   <= '0;
					rows_q  <= row_count;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (last_row) begin
						state_q <= ST_DRAIN;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						if (!stat.fail) begin
							found_q <= 1'b1;
							hit_q   <= scan_q[HIT_W-1:0];
							state_q <= ST_DONE;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= ST_REGION;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						m_found_q <= found_q;
						m_hit_q   <= hit_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready    = state_q == ST_IDLE;
	assign cfg_ready   = 1'b1;
	assign m_tvalid    = m_valid_q;
	assign m_tdata     = OUT_TDATA_W'(m_hit_q);
	assign m_tuser     = m_found_q;
	assign dims        = dims_q;
	assign scan_region = scan_q;
	assign scan_row    = row_q;

endmodule

/* bench/testbench.sv */
module testbench;
	import ppl_pkg::*;

	// Table sizes; these match the default parameters of the core.
	localparam int MAX_REGIONS     = 16;
	localparam int MAX_CONSTRAINTS = 16;
	localparam int MAX_DIMS        = 4;

	// Notable Q16.16 values.
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;

	// A write beat updates the tables as it is accepted, so this settle time after the last
	// result covers any write still in flight before a register is changed.
	localparam int SETTLE_CYCLES   = 8;
	// Extra cycles after the last result before the verdict.
	localparam int TAIL_CYCLES     = 40;
	// Long back-pressure stretch on the result side.
	localparam int HOLD_OFF_CYCLES = 400;
	// A full scan and the long stretch above both end well inside this limit,
	// so this many cycles without any accepted beat means the core is stuck.
	localparam int STALL_LIMIT     = 4000;
	// Useful beats per random phase and in the whole random part.
	localparam int PHASE_ITEMS     = 50;
	localparam int RANDOM_ITEMS    = 500;

	// Register settings for the first random phases, extremes included. Later
	// phases draw their settings at random.
	localparam int DIMS_PLAN    [8] = '{4, 1, 3, 0, 7, 2, 4, 5};
	localparam int REGIONS_PLAN [8] = '{16, 16, 5, 1, 31, 0, 8, 16};

	// One input beat, split into its fields.
	typedef struct packed {
		op_t              op;
		logic [3:0]       region;
		logic [3:0]       row;
		logic [1:0]       col;
		logic [31:0]      coef;
		logic [31:0]      bound;
		logic [4:0]       count;
		logic [3:0][31:0] point;
	} beat_t;

	// One result beat: hit flag and region index.
	typedef struct packed {
		logic       found;
		logic [3:0] region;
	} hit_t;

	localparam hit_t MISS        = '{found: 1'b0, region: 4'd0};
	localparam hit_t HIT_REGION0 = '{found: 1'b1, region: 4'd0};

	typedef enum {
		STEP_BEAT,
		STEP_CFG
	} step_kind_t;

	// One row of the directed table: either a beat, with an optional result typed
	// in by hand, or a register write.
	typedef struct {
		step_kind_t                kind;
		beat_t                     beat;
		bit                        typed;
		hit_t                      want;
		logic [CFG_INDEX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]     value;
	} step_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic [IN_TUSER_W-1:0]   s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [OUT_TUSER_W-1:0]  m_tuser;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// Shadow copy of the region table and the two registers. The written flags
	// keep the stimulus from activating a region whose rows hold unwritten values.
	logic signed [31:0] coef_tab  [MAX_REGIONS][MAX_CONSTRAINTS][MAX_DIMS];
	logic signed [31:0] bound_tab [MAX_REGIONS][MAX_CONSTRAINTS];
	bit                 coef_set  [MAX_REGIONS][MAX_CONSTRAINTS][MAX_DIMS];
	bit                 bound_set [MAX_REGIONS][MAX_CONSTRAINTS];
	logic [4:0]         rows_tab  [MAX_REGIONS] = '{default: '0};
	bit                 active_tab[MAX_REGIONS];
	logic [2:0]         dims_cfg = 3'd1;
	logic [4:0]         regions_cfg = 5'd0;

	// Results still owed by the core, oldest first.
	hit_t   pending_hits[$];
	step_t  directed_steps[$];
	hit_t   oldest_hit;

	int     useful_beats = 0;
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     steady = 1'b0;
	bit     hold_off_req = 1'b0;

	polyhedral_point_location_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Random Q16.16 value. Extremes and small magnitudes are favored so that rows
	// both hold and fail often enough; the rest are raw 32-bit patterns.
	function automatic logic [31:0] pick_q16();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
			3: return '0;
			4, 5, 6: return {{13{raw[18]}}, raw[18:0]};
			default: return raw;
		endcase
	endfunction

	// A beat with every field random; callers override what matters to them.
	function automatic beat_t random_beat();
		beat_t b;
		b.op     = op_t'($urandom_range(0, 3));
		b.region = 4'($urandom);
		b.row    = 4'($urandom);
		b.col    = 2'($urandom);
		b.coef   = pick_q16();
		b.bound  = pick_q16();
		b.count  = 5'($urandom);
		for (int c = 0; c < 4; c++)
			b.point[c] = pick_q16();
		return b;
	endfunction

	// Idle length in cycles for either side: mostly none or short, a few long.
	function automatic int gap_cycles();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// Applies a write beat to the shadow table. Returns 1 when the write takes
	// effect, 0 when the core must ignore it.
	function automatic bit table_write(beat_t b);
		int nreg;
		nreg = (regions_cfg > MAX_REGIONS) ? MAX_REGIONS : regions_cfg;
		if (b.region >= nreg)
			return 1'b0;
		case (b.op)
			OP_WR_COEF: begin
				coef_tab[b.region][b.row][b.col] = b.coef;
				coef_set[b.region][b.row][b.col] = 1'b1;
			end
			OP_WR_BOUND: begin
				bound_tab[b.region][b.row] = b.bound;
				bound_set[b.region][b.row] = 1'b1;
			end
			default: begin
				// A count of zero or above the row limit leaves the region as it was.
				if (b.count == 0 || b.count > MAX_CONSTRAINTS)
					return 1'b0;
				rows_tab[b.region]   = b.count;
				active_tab[b.region] = 1'b1;
			end
		endcase
		return 1'b1;
	endfunction

	// Finds the lowest active searched region that contains the point. Each row
	// is checked exactly as K * 2^16 - sum(H * z) >= 0 in a wide signed sum.
	function automatic hit_t region_search(beat_t b);
		hit_t              h;
		int                nreg;
		int                nd;
		logic signed [71:0] acc;
		bit                holds;
		h = MISS;
		nreg = (regions_cfg > MAX_REGIONS) ? MAX_REGIONS : regions_cfg;
		// A dimension setting of zero acts as one; settings past the limit clamp.
		nd = (dims_cfg == 0) ? 1 : (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
		for (int i = 0; i < nreg; i++) begin
			if (!h.found && active_tab[i]) begin
				holds = 1'b1;
				for (int r = 0; r < rows_tab[i]; r++) begin
					acc = bound_tab[i][r];
					acc = acc <<< FRAC_BITS;
					for (int c = 0; c < nd; c++)
						acc = acc - coef_tab[i][r][c] * $signed(b.point[c]);
					if (acc < 0)
						holds = 1'b0;
				end
				if (holds) begin
					h.found  = 1'b1;
					h.region = 4'(i);
				end
			end
		end
		return h;
	endfunction

	function automatic void add_write(op_t op, int region, int row, int col,
			logic [31:0] value, int count);
		step_t s;
		s.kind         = STEP_BEAT;
		s.beat         = random_beat();
		s.beat.op      = op;
		s.beat.region  = 4'(region);
		s.beat.row     = 4'(row);
		s.beat.col     = 2'(col);
		s.beat.coef    = value;
		s.beat.bound   = value;
		s.beat.count   = 5'(count);
		s.typed        = 1'b0;
		s.want         = MISS;
		directed_steps.push_back(s);
	endfunction

	function automatic void add_locate(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
			logic [31:0] p3, bit typed, hit_t want);
		step_t s;
		s.kind     = STEP_BEAT;
		s.beat     = random_beat();
		s.beat.op  = OP_LOCATE;
		s.beat.point = {p3, p2, p1, p0};
		s.typed    = typed;
		s.want     = want;
		directed_steps.push_back(s);
	endfunction

	function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, int value);
		step_t s;
		s.kind  = STEP_CFG;
		s.idx   = idx;
		s.value = CFG_DATA_W'(value);
		directed_steps.push_back(s);
	endfunction

	// Offers one beat after a random idle gap and holds it until the core takes
	// it. The expected result, or the table update, is booked at acceptance.
	task automatic offer_beat(beat_t b, bit typed, hit_t want);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = b.op;
		s_tdata  = {1'b0, b.point, b.count, b.bound, b.coef, b.col, b.row, b.region};
		do @(posedge clk); while (!s_tready);
		if (b.op == OP_LOCATE) begin
			pending_hits.push_back(typed ? want : region_search(b));
			useful_beats++;
		end else if (table_write(b)) begin
			useful_beats++;
		end
		@(negedge clk);
	endtask

	// Stops offering beats until every owed result is out, then lets any write
	// beat still in flight finish.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_DIMS)
			dims_cfg = value[2:0];
		else
			regions_cfg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Loads a region with n rows: every coefficient and bound of those rows that
	// has never been written gets a value first, some others are rewritten, and
	// the count write comes last so the region never exposes an unwritten entry.
	task automatic build_region(int r, int n);
		beat_t b;
		for (int row = 0; row < n; row++) begin
			for (int c = 0; c < MAX_DIMS; c++) begin
				if (!coef_set[r][row][c] || $urandom_range(0, 4) == 0) begin
					b = random_beat();
					b.op     = OP_WR_COEF;
					b.region = 4'(r);
					b.row    = 4'(row);
					b.col    = 2'(c);
					offer_beat(b, 1'b0, MISS);
				end
			end
			if (!bound_set[r][row] || $urandom_range(0, 4) == 0) begin
				b = random_beat();
				b.op     = OP_WR_BOUND;
				b.region = 4'(r);
				b.row    = 4'(row);
				offer_beat(b, 1'b0, MISS);
			end
		end
		b = random_beat();
		b.op     = OP_WR_COUNT;
		b.region = 4'(r);
		b.count  = 5'(n);
		offer_beat(b, 1'b0, MISS);
	endtask

	// Result side: random ready gaps, plus one long hold-off on request. The
	// hold-off is timed here so the sender keeps offering beats meanwhile.
	initial begin : result_sink
		int n;
		m_tready = 1'b0;
		while (!arst_n)
			@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				n = gap_cycles();
				if (n > 0) begin
					m_tready = 1'b0;
					repeat (n) @(negedge clk);
				end
			end
			m_tready = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	// Every accepted result beat is compared with the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: found=%0b region=%0d",
						m_tuser[0], m_tdata[HIT_W-1:0]);
			end else begin
				oldest_hit = pending_hits.pop_front();
				if (oldest_hit.found !== m_tuser[0] ||
						oldest_hit.region !== m_tdata[HIT_W-1:0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected found=%0b region=%0d, got found=%0b region=%0d",
							oldest_hit.found, oldest_hit.region,
							m_tuser[0], m_tdata[HIT_W-1:0]);
				end
			end
		end
	end

	// Watchdog: the run is stuck once no channel has moved a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == STALL_LIMIT) begin
				$display("polyhedral_point_location_core regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		beat_t b;
		int    phase;
		int    start;
		int    random_useful;
		int    nreg;
		int    roll;
		int    n;

		// Directed part. After reset no region is searched, so every write is
		// ignored and every locate misses.
		add_locate(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1, MISS);
		add_write(OP_WR_COEF, 0, 0, 0, Q_ONE, 0);
		add_write(OP_WR_COUNT, 0, 0, 0, '0, 1);
		add_locate('0, '0, '0, '0, 1'b1, MISS);
		// A region setting above the table size acts as the table size, and a
		// dimension setting above the limit acts as the limit.
		add_cfg(REG_REGIONS, 31);
		add_cfg(REG_DIMS, 7);
		// One row in region 0 with the coefficient extremes and the largest bound.
		add_write(OP_WR_COEF, 0, 0, 0, Q_ONE, 0);
		add_write(OP_WR_COEF, 0, 0, 1, Q_MIN, 0);
		add_write(OP_WR_COEF, 0, 0, 2, '0, 0);
		add_write(OP_WR_COEF, 0, 0, 3, Q_MAX, 0);
		add_write(OP_WR_BOUND, 0, 0, 0, Q_MAX, 0);
		// Counts of zero and above the row limit must not activate the region.
		add_write(OP_WR_COUNT, 0, 0, 0, '0, 0);
		add_write(OP_WR_COUNT, 0, 0, 0, '0, 31);
		add_locate('0, '0, '0, '0, 1'b1, MISS);
		add_write(OP_WR_COUNT, 0, 0, 0, '0, 1);
		// The origin satisfies any row with a positive bound.
		add_locate('0, '0, '0, '0, 1'b1, HIT_REGION0);
		add_locate(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, MISS);
		add_locate(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, MISS);
		// Lowest bound, then a count rewrite that keeps the stored row.
		add_write(OP_WR_BOUND, 0, 0, 0, Q_MIN, 0);
		add_write(OP_WR_COUNT, 0, 0, 0, '0, 1);
		add_locate('0, '0, '0, '0, 1'b1, MISS);
		// Dimension zero acts as one. With only the first column in use, the
		// lowest point meets the lowest bound with equality.
		add_cfg(REG_DIMS, 0);
		add_locate(Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, MISS);
		add_write(OP_WR_COEF, 15, 15, 3, Q_MIN, 0);
		// Writes past the searched slots are dropped.
		add_cfg(REG_REGIONS, 1);
		add_write(OP_WR_COEF, 1, 0, 0, Q_MAX, 0);
		add_locate(32'd1, '0, '0, '0, 1'b0, MISS);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[k]) begin
			if (directed_steps[k].kind == STEP_CFG) begin
				drain_results();
				write_register(directed_steps[k].idx, directed_steps[k].value);
			end else begin
				offer_beat(directed_steps[k].beat, directed_steps[k].typed,
					directed_steps[k].want);
			end
		end

		// Random part in phases. Each phase starts from an idle core with new
		// register settings; every fourth phase runs without idle gaps, and the
		// second phase also holds the result side off long enough to stall input.
		random_useful = 0;
		for (phase = 0; random_useful < RANDOM_ITEMS; phase++) begin
			drain_results();
			steady = (phase % 4 == 3);
			if (phase < 8) begin
				write_register(REG_DIMS, CFG_DATA_W'(DIMS_PLAN[phase]));
				write_register(REG_REGIONS, CFG_DATA_W'(REGIONS_PLAN[phase]));
			end else begin
				write_register(REG_DIMS, CFG_DATA_W'($urandom_range(0, 7)));
				write_register(REG_REGIONS, CFG_DATA_W'($urandom_range(0, 31)));
			end
			if (phase == 1)
				hold_off_req = 1'b1;
			start = useful_beats;
			while (useful_beats - start < PHASE_ITEMS) begin
				nreg = (regions_cfg > MAX_REGIONS) ? MAX_REGIONS : regions_cfg;
				roll = $urandom_range(0, 99);
				if (roll < 40 && nreg > 0) begin
					// Mostly short regions; now and then one with every row.
					roll = $urandom_range(0, 99);
					if (roll < 4)
						n = MAX_CONSTRAINTS;
					else if (roll < 14)
						n = $urandom_range(4, 8);
					else
						n = $urandom_range(1, 3);
					build_region($urandom_range(0, nreg - 1), n);
				end else if (roll < 80) begin
					b = random_beat();
					b.op = OP_LOCATE;
					offer_beat(b, 1'b0, MISS);
				end else begin
					// Noise: stray writes anywhere, and only illegal counts, so no
					// region is ever activated over rows that were never loaded.
					b = random_beat();
					b.op = op_t'($urandom_range(0, 2));
					if (b.op == OP_WR_COUNT)
						b.count = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
					offer_beat(b, 1'b0, MISS);
				end
			end
			random_useful += useful_beats - start;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		mismatches += pending_hits.size();
		if (mismatches == 0)
			$display("polyhedral_point_location_core regression: pass");
		else
			$display("polyhedral_point_location_core regression: fail");
		$finish;
	end

endmodule
